FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: hdl/tqrr_pkg.sv
// ----------------------------------------------------------------------------
// tqrr_pkg
// Shared constants, command and result types for the round-robin packet mux.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tqrr_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = 32;

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  // two-entry decoupling queues
  localparam int unsigned SQ_PTR_W = 1;
  localparam int unsigned SQ_CNT_W = 2;
  localparam logic [SQ_CNT_W-1:0] SQ_FULL = 2'd2;

  localparam logic PORT0 = 1'b0;
  localparam logic PORT1 = 1'b1;

  typedef struct packed {
    logic              wr0;
    logic [DATA_W-1:0] data0;
    logic              wr1;
    logic [DATA_W-1:0] data1;
    logic              mv;
    logic              mv_sel;
    logic              mv_byp;
    logic              emit;
    logic              out_byp;
    logic [CNT_W-1:0]  rcv;
    logic [CNT_W-1:0]  drp;
  } cmd_t;

  typedef struct packed {
    logic              out_valid;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  rcv;
    logic [CNT_W-1:0]  drp;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0]       inc);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {{(CNT_W - 1){1'b0}}, inc};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tqrr_front.sv
// ----------------------------------------------------------------------------
// tqrr_front
// Tracks queue fill levels, round-robin pointer and counters; turns each item
// into a command for the data path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tqrr_front import tqrr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              in0_valid_i,
  input  wire logic [DATA_W-1:0] in0_data_i,
  input  wire logic              in1_valid_i,
  input  wire logic [DATA_W-1:0] in1_data_i,
  input  wire logic              tick_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_ready_i
);

  logic [FILL_W-1:0] fill0_q, fill0_d, fill1_q, fill1_d, fillo_q, fillo_d;
  logic              last_q, last_d;
  logic [CNT_W-1:0]  rcv_q, rcv_d, drp_q, drp_d;

  logic              acc;
  logic              wr0, wr1, drop0, drop1;
  logic [FILL_W-1:0] f0b, f1b, fob;
  logic              e0, e1, pick0, pick1, mv, sel, emit;

  assign acc         = push_i && cmd_ready_i;
  assign full_o      = !cmd_ready_i;
  assign cmd_valid_o = push_i;

  always_comb begin
    wr0   = in0_valid_i && (fill0_q != FILL_MAX);
    wr1   = in1_valid_i && (fill1_q != FILL_MAX);
    drop0 = in0_valid_i && !wr0;
    drop1 = in1_valid_i && !wr1;
    f0b   = fill0_q + FILL_W'(wr0);
    f1b   = fill1_q + FILL_W'(wr1);
    e0    = (f0b == '0);
    e1    = (f1b == '0);
    pick0 = !e0 && (e1 || (last_q == PORT1));
    pick1 = !e1 && !pick0;
    mv    = tick_i && (fillo_q != FILL_MAX) && (pick0 || pick1);
    sel   = pick0 ? PORT0 : PORT1;
    fob   = fillo_q + FILL_W'(mv);
    emit  = tick_i && (fob != '0);

    fill0_d = f0b - FILL_W'(mv && (sel == PORT0));
    fill1_d = f1b - FILL_W'(mv && (sel == PORT1));
    fillo_d = fob - FILL_W'(emit);
    last_d  = mv ? sel : last_q;
    rcv_d   = sat_add(rcv_q, {1'b0, in0_valid_i} + {1'b0, in1_valid_i});
    drp_d   = sat_add(drp_q, {1'b0, drop0} + {1'b0, drop1});

    cmd_o.wr0     = wr0;
    cmd_o.data0   = in0_data_i;
    cmd_o.wr1     = wr1;
    cmd_o.data1   = in1_data_i;
    cmd_o.mv      = mv;
    cmd_o.mv_sel  = sel;
    cmd_o.mv_byp  = mv && ((sel == PORT0) ? (fill0_q == '0) : (fill1_q == '0));
    cmd_o.emit    = emit;
    cmd_o.out_byp = (fillo_q == '0);
    cmd_o.rcv     = rcv_d;
    cmd_o.drp     = drp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill0_q <= '0;
      fill1_q <= '0;
      fillo_q <= '0;
      last_q  <= PORT0;
      rcv_q   <= '0;
      drp_q   <= '0;
    end else if (acc) begin
      fill0_q <= fill0_d;
      fill1_q <= fill1_d;
      fillo_q <= fillo_d;
      last_q  <= last_d;
      rcv_q   <= rcv_d;
      drp_q   <= drp_d;
    end
  end

  `ASSERT_PROP(a_fill_bound, (fill0_q <= FILL_MAX) && (fill1_q <= FILL_MAX) && (fillo_q <= FILL_MAX), "queue fill above depth")
  `ASSERT_PROP(a_out_byp_needs_move, (acc && cmd_o.emit && cmd_o.out_byp) |-> cmd_o.mv, "emit from empty output queue without move")
  `ASSERT_PROP(a_drop_le_rcv, drp_q <= rcv_q, "dropped count above received count")
  `ASSERT_PROP(a_last_holds_idle, !acc |=> $stable(last_q), "round-robin pointer moved without an item")

endmodule

`default_nettype wire

FILE: hdl/tqrr_cmd_queue.sv
// ----------------------------------------------------------------------------
// tqrr_cmd_queue
// Two-entry command queue decoupling the front from the data path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tqrr_cmd_queue import tqrr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  input  wire cmd_t wr_data_i,
  output logic      wr_ready_o,
  output logic      rd_valid_o,
  output cmd_t      rd_data_o,
  input  wire logic rd_ready_i
);

  cmd_t                mem_q [2];
  logic [SQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [SQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                wr, rd;

  assign wr_ready_o = (cnt_q != SQ_FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign cnt_d      = cnt_q + SQ_CNT_W'(wr) - SQ_CNT_W'(rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tqrr_back.sv
// ----------------------------------------------------------------------------
// tqrr_back
// Packet data path: two input queues, the output queue and a two-entry
// result queue toward the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tqrr_back import tqrr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   cmd_ready_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic                   out_valid_o,
  output logic [DATA_W-1:0]      out_data_o,
  output logic [CNT_W-1:0]       received_total_o,
  output logic [CNT_W-1:0]       dropped_total_o
);

  logic [DATA_W-1:0] q0_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] q1_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] qo_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head0_q, tail0_q, head1_q, tail1_q, heado_q, tailo_q;

  res_t                res_mem_q [2];
  logic [SQ_PTR_W-1:0] res_wptr_q, res_rptr_q;
  logic [SQ_CNT_W-1:0] res_cnt_q;

  logic              exec, res_rd;
  logic              w0, w1, r0, r1, ow, orr;
  logic [DATA_W-1:0] mv_data, emit_data;
  res_t              res_in, res_out;

  assign cmd_ready_o = (res_cnt_q != SQ_FULL);
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign empty_o     = (res_cnt_q == '0);
  assign res_rd      = pop_i && !empty_o;

  always_comb begin
    w0  = exec && cmd_i.wr0 &&
          !(cmd_i.mv && cmd_i.mv_byp && (cmd_i.mv_sel == PORT0));
    w1  = exec && cmd_i.wr1 &&
          !(cmd_i.mv && cmd_i.mv_byp && (cmd_i.mv_sel == PORT1));
    r0  = exec && cmd_i.mv && !cmd_i.mv_byp && (cmd_i.mv_sel == PORT0);
    r1  = exec && cmd_i.mv && !cmd_i.mv_byp && (cmd_i.mv_sel == PORT1);
    ow  = exec && cmd_i.mv && !(cmd_i.emit && cmd_i.out_byp);
    orr = exec && cmd_i.emit && !cmd_i.out_byp;

    if (cmd_i.mv_byp) begin
      mv_data = (cmd_i.mv_sel == PORT0) ? cmd_i.data0 : cmd_i.data1;
    end else begin
      mv_data = (cmd_i.mv_sel == PORT0) ? q0_mem[head0_q] : q1_mem[head1_q];
    end
    emit_data = cmd_i.out_byp ? mv_data : qo_mem[heado_q];

    res_in.out_valid = cmd_i.emit;
    res_in.data      = cmd_i.emit ? emit_data : '0;
    res_in.rcv       = cmd_i.rcv;
    res_in.drp       = cmd_i.drp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head0_q    <= '0;
      tail0_q    <= '0;
      head1_q    <= '0;
      tail1_q    <= '0;
      heado_q    <= '0;
      tailo_q    <= '0;
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (w0) begin
        tail0_q <= ptr_inc(tail0_q);
      end
      if (r0) begin
        head0_q <= ptr_inc(head0_q);
      end
      if (w1) begin
        tail1_q <= ptr_inc(tail1_q);
      end
      if (r1) begin
        head1_q <= ptr_inc(head1_q);
      end
      if (ow) begin
        tailo_q <= ptr_inc(tailo_q);
      end
      if (orr) begin
        heado_q <= ptr_inc(heado_q);
      end
      if (exec) begin
        res_wptr_q <= res_wptr_q + 1'b1;
      end
      if (res_rd) begin
        res_rptr_q <= res_rptr_q + 1'b1;
      end
      res_cnt_q <= res_cnt_q + SQ_CNT_W'(exec) - SQ_CNT_W'(res_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (w0) begin
      q0_mem[tail0_q] <= cmd_i.data0;
    end
    if (w1) begin
      q1_mem[tail1_q] <= cmd_i.data1;
    end
    if (ow) begin
      qo_mem[tailo_q] <= mv_data;
    end
    if (exec) begin
      res_mem_q[res_wptr_q] <= res_in;
    end
  end

  assign res_out          = res_mem_q[res_rptr_q];
  assign out_valid_o      = res_out.out_valid;
  assign out_data_o       = res_out.data;
  assign received_total_o = res_out.rcv;
  assign dropped_total_o  = res_out.drp;

  `ASSERT_PROP(a_res_cnt_bound, res_cnt_q <= SQ_FULL, "result queue count above depth")
  `ASSERT_PROP(a_idle_data_zero, (!empty_o && !out_valid_o) |-> (out_data_o == '0), "idle result carries data")
  `ASSERT_PROP(a_ptr_bound, (head0_q <= PTR_LAST) && (head1_q <= PTR_LAST) && (heado_q <= PTR_LAST), "queue pointer out of range")
  `ASSERT_NEVER(a_no_exec_when_full, (res_cnt_q == SQ_FULL) && exec, "command executed into full result queue")

endmodule

`default_nettype wire

FILE: hdl/two_queue_round_robin_packet_mux.sv
// ----------------------------------------------------------------------------
// two_queue_round_robin_packet_mux
// Two-port packet mux: per-port input queues, two-way round-robin into one
// output queue, saturating received and dropped counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in0/in1 valid and data plus tick, raise push; the
//   item is taken at a clock edge with push high and full low. Each item is
//   one step: store arriving packets (drop and count when a port queue is
//   full); on tick, move at most one packet by round robin, emit at most one.
//   Result channel: while empty is low the oldest result is on the out_*,
//   received_total and dropped_total ports; pop high takes it. Exactly one
//   result leaves per item, out_valid low when no packet was emitted.
//   Items are registered in the command queue, results in the result queue.
//   Throughput: one item per cycle while full is low; every step is settled
//   in the front in the cycle it is taken, and the data path executes one
//   command a cycle unless the result queue is full. A stalled consumer fills
//   both two-entry queues, result first, and full rises; nothing is lost.
//   Reset: all queues empty, round robin points at port 0, counters zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_queue_round_robin_packet_mux import tqrr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in0_valid_i,
  input  wire logic [DATA_W-1:0] in0_data_i,
  input  wire logic              in1_valid_i,
  input  wire logic [DATA_W-1:0] in1_data_i,
  input  wire logic              tick_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_valid_o,
  output logic [DATA_W-1:0]      out_data_o,
  output logic [CNT_W-1:0]       received_total_o,
  output logic [CNT_W-1:0]       dropped_total_o
);

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  tqrr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in0_valid_i (in0_valid_i),
    .in0_data_i  (in0_data_i),
    .in1_valid_i (in1_valid_i),
    .in1_data_i  (in1_data_i),
    .tick_i      (tick_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  tqrr_cmd_queue u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_data_i  (front_cmd),
    .wr_ready_o (front_ready),
    .rd_valid_o (back_valid),
    .rd_data_o  (back_cmd),
    .rd_ready_i (back_ready)
  );

  tqrr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (back_valid),
    .cmd_i            (back_cmd),
    .cmd_ready_o      (back_ready),
    .empty_o          (empty),
    .pop_i            (pop),
    .out_valid_o      (out_valid_o),
    .out_data_o       (out_data_o),
    .received_total_o (received_total_o),
    .dropped_total_o  (dropped_total_o)
  );

endmodule

`default_nettype wire
